FILE: design/tsfs_pkg.sv
// ----------------------------------------------------------------------------
// Touch sample filter sequencer package
// Item types, command and mode codes, and register constants.
// ----------------------------------------------------------------------------
package tsfs_pkg;

  localparam int unsigned LimitW    = 10;
  localparam int unsigned SampleInW = 10;
  localparam int unsigned PosW      = 10;

  localparam logic [1:0] CMD_PEN_CHANGE = 2'd0;
  localparam logic [1:0] CMD_CONV_DONE  = 2'd1;
  localparam logic [1:0] CMD_TICK       = 2'd2;

  localparam logic [1:0] MODE_KEEP      = 2'd0;
  localparam logic [1:0] MODE_WAIT_DOWN = 2'd1;
  localparam logic [1:0] MODE_WAIT_UP   = 2'd2;
  localparam logic [1:0] MODE_MEASURE   = 2'd3;

  localparam logic [LimitW-1:0] LIMIT_RESET = LimitW'(10);

  typedef struct packed {
    logic [1:0]           command;
    logic                 pen_up;
    logic [SampleInW-1:0] x_sample;
    logic [SampleInW-1:0] y_sample;
  } tsfs_in_t;

  typedef struct packed {
    logic            report_valid;
    logic            touch_pressed;
    logic [PosW-1:0] x_position;
    logic [PosW-1:0] y_position;
    logic [1:0]      next_mode;
    logic            start_conversion;
    logic            arm_timer;
  } tsfs_out_t;

endpackage

FILE: design/tsfs_in_reg.sv
// ----------------------------------------------------------------------------
// Touch sample filter input register
// Captures one event item and holds it until the sequencer takes it.
// ----------------------------------------------------------------------------
module tsfs_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tsfs_pkg::tsfs_in_t in_item_i,
  input  logic              advance_i,
  output logic              item_valid_o,
  output tsfs_pkg::tsfs_in_t item_o
);
  import tsfs_pkg::*;

  logic     valid_q;
  tsfs_in_t item_q;

  assign in_ready_o   = !valid_q || advance_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

FILE: design/tsfs_seq.sv
// ----------------------------------------------------------------------------
// Touch sample filter sequencer step
// Sample stores, count, limit register and the single-pass filter decision.
// ----------------------------------------------------------------------------
module tsfs_seq #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  input  tsfs_pkg::tsfs_in_t              item_i,
  input  logic                            advance_i,
  input  logic                            cfg_we_i,
  input  logic [tsfs_pkg::LimitW-1:0]     cfg_wdata_i,
  output tsfs_pkg::tsfs_out_t             result_o
);
  import tsfs_pkg::*;

  localparam int unsigned CmpW = (SAMPLE_BITS > LimitW) ? SAMPLE_BITS : LimitW;
  localparam int unsigned SumW = SAMPLE_BITS + 2;
  localparam logic [1:0]  LastIdx = 2'd3;

  logic [1:0]             count_q, count_d;
  logic [LimitW-1:0]      limit_q;
  logic [SAMPLE_BITS-1:0] x_store_q [3];
  logic [SAMPLE_BITS-1:0] y_store_q [3];
  logic [SAMPLE_BITS-1:0] xs, ys;
  logic [SAMPLE_BITS-1:0] xv [4];
  logic [SAMPLE_BITS-1:0] yv [4];
  logic                   x_ok, y_ok;
  logic [SumW-1:0]        x_sum, y_sum;
  logic                   store_we;
  logic                   proc;
  tsfs_out_t              res;

  function automatic logic [SAMPLE_BITS-1:0] dev(
    input logic [SAMPLE_BITS-1:0] s,
    input logic [SAMPLE_BITS-1:0] a,
    input logic [SAMPLE_BITS-1:0] b
  );
    logic [SAMPLE_BITS:0]   sum;
    logic [SAMPLE_BITS-1:0] m;
    sum = {1'b0, a} + {1'b0, b};
    m   = sum[SAMPLE_BITS:1];
    return (s > m) ? (s - m) : (m - s);
  endfunction

  assign proc = item_valid_i && advance_i;
  assign xs   = SAMPLE_BITS'(item_i.x_sample);
  assign ys   = SAMPLE_BITS'(item_i.y_sample);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xv[i] = x_store_q[i];
      yv[i] = y_store_q[i];
    end
    xv[3] = xs;
    yv[3] = ys;
  end

  assign x_ok = (CmpW'(dev(xv[2], xv[0], xv[1])) <= CmpW'(limit_q)) &&
                (CmpW'(dev(xv[3], xv[1], xv[2])) <= CmpW'(limit_q));
  assign y_ok = (CmpW'(dev(yv[2], yv[0], yv[1])) <= CmpW'(limit_q)) &&
                (CmpW'(dev(yv[3], yv[1], yv[2])) <= CmpW'(limit_q));

  assign x_sum = SumW'(xv[0]) + SumW'(xv[1]) + SumW'(xv[2]) + SumW'(xv[3]);
  assign y_sum = SumW'(yv[0]) + SumW'(yv[1]) + SumW'(yv[2]) + SumW'(yv[3]);

  always_comb begin
    res      = '0;
    count_d  = count_q;
    store_we = 1'b0;
    case (item_i.command) inside
      CMD_PEN_CHANGE, CMD_TICK: begin
        if (item_i.pen_up) begin
          res.report_valid = 1'b1;
          res.next_mode    = MODE_WAIT_DOWN;
        end else begin
          res.next_mode        = MODE_MEASURE;
          res.start_conversion = 1'b1;
        end
      end
      CMD_CONV_DONE: begin
        if (item_i.pen_up) begin
          res.report_valid = 1'b1;
          res.next_mode    = MODE_WAIT_DOWN;
          count_d          = '0;
        end else begin
          store_we = (count_q != LastIdx);
          if (count_q == LastIdx) begin
            if (x_ok && y_ok) begin
              res.report_valid  = 1'b1;
              res.touch_pressed = 1'b1;
              res.x_position    = PosW'(x_sum[SumW-1:2]);
              res.y_position    = PosW'(y_sum[SumW-1:2]);
            end
            count_d       = '0;
            res.next_mode = MODE_WAIT_UP;
            res.arm_timer = 1'b1;
          end else begin
            count_d              = count_q + 2'd1;
            res.next_mode        = MODE_MEASURE;
            res.start_conversion = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      limit_q <= LIMIT_RESET;
    end else begin
      if (proc) begin
        count_q <= count_d;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && store_we) begin
      x_store_q[count_q] <= xs;
      y_store_q[count_q] <= ys;
    end
  end

  a_press_ends_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && res.touch_pressed |->
      res.report_valid && res.arm_timer && (res.next_mode == MODE_WAIT_UP))
    else $error("press report without wait-for-pen-up and timer re-arm");

  a_conv_measures: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && res.start_conversion |-> (res.next_mode == MODE_MEASURE) && !res.report_valid)
    else $error("conversion requested outside measure mode");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !proc |=> $stable(count_q))
    else $error("sample count moved without an item");

  a_fourth_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (item_i.command == CMD_CONV_DONE) && (item_i.pen_up || count_q == LastIdx)
      |=> count_q == 2'd0)
    else $error("sample count not cleared");

endmodule

FILE: design/tsfs_out_reg.sv
// ----------------------------------------------------------------------------
// Touch sample filter result register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module tsfs_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  input  tsfs_pkg::tsfs_out_t res_i,
  output logic                advance_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tsfs_pkg::tsfs_out_t out_item_o
);
  import tsfs_pkg::*;

  logic      valid_q;
  tsfs_out_t item_q;

  assign advance_o   = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      item_q <= res_i;
    end
  end

endmodule

FILE: design/touch_sample_filter_sequencer_core.sv
// ----------------------------------------------------------------------------
// Touch sample filter sequencer core
// Event sequencer for a touch panel with four-sample deviation filtering.
//
//   Channel | Signals                                  | Direction
//   --------+------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, in_item_i        | event in
//   out     | out_valid_o, out_ready_i, out_item_o     | result out
//   cfg     | cfg_we_i, cfg_wdata_i                    | limit write
//
// One item per cycle sustained while out_ready_i is high; each item passes the input
// register, then the result register. Each event gives exactly one result item.
// Reset clears the sample count and sets the deviation limit to 10.
// A stalled result register holds the input register, which holds in_ready_o.
// ----------------------------------------------------------------------------
module touch_sample_filter_sequencer_core #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tsfs_pkg::tsfs_in_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tsfs_pkg::tsfs_out_t         out_item_o,
  input  logic                        cfg_we_i,
  input  logic [tsfs_pkg::LimitW-1:0] cfg_wdata_i
);
  import tsfs_pkg::*;

  logic      advance;
  logic      item_valid;
  tsfs_in_t  item;
  tsfs_out_t result;

  tsfs_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  tsfs_seq #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .advance_i    (advance),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .result_o     (result)
  );

  tsfs_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (item_valid),
    .res_i       (result),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
